// File: rtl/ascii_art_box_char_converter_macros.svh
// Assertion macros for the box character converter.
// Every macro samples on the rising edge of clock and is off while reset is high.
`ifndef ASCII_ART_BOX_CHAR_CONVERTER_MACROS_SVH
`define ASCII_ART_BOX_CHAR_CONVERTER_MACROS_SVH

// Check a condition on every cycle.
`define AABC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check a consequence in the same cycle as its cause.
`define AABC_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequence in the cycle after its cause.
`define AABC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/aabc_pkg.sv
`default_nettype none

package aabc_pkg;

   // Request kinds carried on req_tuser
   typedef enum logic [1:0] {
      FUNC_TEXT  = 2'd0,
      FUNC_DRAIN = 2'd1,
      FUNC_END   = 2'd2
   } func_type;

   // Pending drain work
   typedef enum logic [1:0] {
      DRAIN_NONE     = 2'd0,
      DRAIN_REST     = 2'd1,
      DRAIN_REST_END = 2'd2,
      DRAIN_FINAL    = 2'd3
   } drain_type;

   // One result transaction
   typedef struct packed {
      logic [23:0] char_bytes;
      logic [1:0]  byte_count;
      logic        more_pending;
      logic        refused;
      logic        text_done;
   } rsp_type;

   // Emitted character for one column
   typedef struct packed {
      logic [23:0] bytes;
      logic [1:0]  count;
   } glyph_type;

   localparam logic [7:0]  CHAR_NL    = 8'h0A;
   localparam logic [7:0]  CHAR_PLUS  = 8'h2B;
   localparam logic [7:0]  CHAR_DASH  = 8'h2D;
   localparam logic [7:0]  CHAR_BAR   = 8'h7C;
   localparam logic [15:0] BOX_LEAD   = 16'hE294;
   localparam logic [23:0] BOX_HORIZ  = 24'hE29480;
   localparam logic [23:0] BOX_VERT   = 24'hE29482;
   localparam logic [1:0]  COUNT_ONE  = 2'd1;
   localparam logic [1:0]  COUNT_BOX  = 2'd3;

   // Mask bits: 0 left, 1 right, 2 up, 3 down
   function automatic logic [7:0] corner_low(input logic [3:0] mask);
      logic [7:0] low;
      case (mask)
         4'd5:    low = 8'h98;
         4'd6:    low = 8'h94;
         4'd7:    low = 8'hB4;
         4'd9:    low = 8'h90;
         4'd10:   low = 8'h8C;
         4'd11:   low = 8'hAC;
         4'd13:   low = 8'hA4;
         4'd14:   low = 8'h9C;
         4'd15:   low = 8'hBC;
         default: low = 8'h00;
      endcase
      return low;
   endfunction

   function automatic logic is_horiz(input logic [7:0] c);
      return (c == CHAR_DASH) || (c == CHAR_PLUS);
   endfunction

   function automatic logic is_vert(input logic [7:0] c);
      return (c == CHAR_BAR) || (c == CHAR_PLUS);
   endfunction

   // Map a middle-line byte and its neighbor mask to output bytes
   function automatic glyph_type box_char(input logic [7:0] c, input logic [3:0] mask);
      glyph_type  g;
      logic [7:0] low;
      low     = corner_low(mask);
      g.bytes = {16'h0000, c};
      g.count = COUNT_ONE;
      case (c)
         CHAR_PLUS: begin
            if (low != 8'h00) begin
               g.bytes = {BOX_LEAD, low};
               g.count = COUNT_BOX;
            end
         end
         CHAR_DASH: begin
            if (mask[1:0] != 2'b00) begin
               g.bytes = BOX_HORIZ;
               g.count = COUNT_BOX;
            end
         end
         CHAR_BAR: begin
            if (mask[3:2] != 2'b00) begin
               g.bytes = BOX_VERT;
               g.count = COUNT_BOX;
            end
         end
         default: begin
         end
      endcase
      return g;
   endfunction

   // Rotate a buffer role index by k, modulo three
   function automatic logic [1:0] role_add(input logic [1:0] r, input logic [1:0] k);
      logic [2:0] s;
      s = {1'b0, r} + {1'b0, k};
      if (s >= 3'd3) begin
         s = s - 3'd3;
      end
      return s[1:0];
   endfunction

endpackage

`default_nettype wire

// File: rtl/aabc_line_mem.sv
`default_nettype none

module aabc_line_mem #(
   parameter int DEPTH = 768,
   parameter int AW    = 10
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [7:0]    rd_data
);

   logic [7:0] line_mem [DEPTH];
   logic [7:0] rd_q_ff;
   logic [7:0] byp_data_ff;
   logic       byp_ff;
   logic       byp_in;

   assign byp_in = wr_en && (wr_addr == rd_addr);

   // Write one byte and read one byte per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[wr_addr] <= wr_data;
      end
      rd_q_ff     <= line_mem[rd_addr];
      byp_data_ff <= wr_data;
   end

   // Track a read that hits the entry written in the same cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else begin
         byp_ff <= byp_in;
      end
   end

   // Forward the new byte over the stale array output
   assign rd_data = byp_ff ? byp_data_ff : rd_q_ff;

endmodule

`default_nettype wire

// File: rtl/aabc_rsp_buf.sv
`default_nettype none

module aabc_rsp_buf (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire aabc_pkg::rsp_type in_item,
   output logic                  in_ready,
   output logic                  out_valid,
   output aabc_pkg::rsp_type     out_item,
   input  wire logic             out_ready
);

   aabc_pkg::rsp_type main_ff;
   aabc_pkg::rsp_type skid_ff;
   logic              main_valid_ff;
   logic              skid_valid_ff;
   logic              main_free;

   assign main_free = out_ready || !main_valid_ff;
   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_item  = main_ff;

   // Advance the output slot and park a transaction in the skid slot on stall
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (main_free) begin
         main_valid_ff <= skid_valid_ff || in_valid;
         skid_valid_ff <= 1'b0;
      end else if (in_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // Move payload without reset
   always_ff @(posedge clock) begin
      if (main_free) begin
         main_ff <= skid_valid_ff ? skid_ff : in_item;
      end else if (in_valid) begin
         skid_ff <= in_item;
      end
   end

endmodule

`default_nettype wire

// File: rtl/ascii_art_box_char_converter.sv
// Channel | Dir | Payload                                              | Handshake
// req     | in  | tdata[7:0] text_byte, tuser[1:0] func                | tvalid/tready
// rsp     | out | tdata char_bytes, byte_count, more_pending, refused;  | tvalid/tready
//         |     | tlast text_done                                      |
//
// One result per request transaction; a request is taken every cycle while the
// skid slot is empty, so the block sustains one transaction per clock.
// The middle line streams through a two-byte window fed by the middle-line memory
// read port, prefetched from next-state addresses; a rotation reloads the window.
// Synchronous reset clears lengths, columns, roles and drain state at once;
// the line memories are never cleared. Each result is registered in the response buffer.
// A stall on rsp holds two results, then req_tready drops.
`default_nettype none

`include "ascii_art_box_char_converter_macros.svh"

module ascii_art_box_char_converter #(
   parameter int LINE_LEN = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] text_byte
   input  wire logic [1:0]  req_tuser,   // [1:0] func
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [23:0] char_bytes, [25:24] byte_count,
                                         // [26] more_pending, [27] refused, zero pad
   output logic             rsp_tlast    // text_done
);

   localparam int DEPTH = 3 * LINE_LEN;
   localparam int MAW   = $clog2(DEPTH);
   localparam int CW    = $clog2(LINE_LEN + 1);
   localparam logic [CW-1:0] LAST_COL = CW'(LINE_LEN - 1);
   localparam logic [CW-1:0] COL_ONE  = CW'(1);

   // Byte address of a column within a role's buffer
   function automatic logic [MAW-1:0] line_addr(input logic [1:0] role,
                                                input logic [CW-1:0] col);
      return MAW'(role) * MAW'(LINE_LEN) + MAW'(col);
   endfunction

   // Control state
   logic [CW-1:0]        col_ff, col_in;
   logic [CW-1:0]        dcol_ff, dcol_in;
   logic [CW-1:0]        alen_ff, alen_in;
   logic [CW-1:0]        mlen_ff, mlen_in;
   logic [1:0]           seen_ff, seen_in;
   logic [1:0]           roles_ff, roles_in;
   aabc_pkg::drain_type  phase_ff, phase_in;

   // Middle-line window and first byte of the incoming line
   logic [7:0]           mprev_ff, mprev_in;
   logic [7:0]           mcur_ff, mcur_in;
   logic [7:0]           first_ff, first_in;

   logic                 req_fire;
   aabc_pkg::func_type   req_func;
   logic [7:0]           req_byte;
   logic [CW-1:0]        ptr, ptr_p1, ptr_in;
   logic [CW-1:0]        col_plus, dcol_plus;
   logic [7:0]           mid_rd, abv_rd;
   logic [3:0]           nbr_mask;
   aabc_pkg::glyph_type  glyph;
   aabc_pkg::rsp_type    rsp_item, out_item;
   logic                 wr_en, rotate, advance, clear;
   logic                 buf_ready;
   logic [MAW-1:0]       wr_addr, mid_addr, abv_addr;

   assign req_tready = buf_ready;
   assign req_fire   = req_tvalid && buf_ready;
   assign req_func   = aabc_pkg::func_type'(req_tuser);
   assign req_byte   = req_tdata;

   assign ptr       = (phase_ff != aabc_pkg::DRAIN_NONE) ? dcol_ff : col_ff;
   assign ptr_p1    = ptr + COL_ONE;
   assign col_plus  = col_ff + COL_ONE;
   assign dcol_plus = dcol_ff + COL_ONE;

   // Gather neighbors of the middle byte at the current column
   assign nbr_mask[0] = (ptr != '0) && aabc_pkg::is_horiz(mprev_ff);
   assign nbr_mask[1] = (ptr_p1 < mlen_ff) && aabc_pkg::is_horiz(mid_rd);
   assign nbr_mask[2] = (ptr < alen_ff) && aabc_pkg::is_vert(abv_rd);
   assign nbr_mask[3] = (req_func == aabc_pkg::FUNC_TEXT) && aabc_pkg::is_vert(req_byte);
   assign glyph       = aabc_pkg::box_char(mcur_ff, nbr_mask);

   // Decode the transaction and update line state
   always_comb begin
      col_in   = col_ff;
      dcol_in  = dcol_ff;
      alen_in  = alen_ff;
      mlen_in  = mlen_ff;
      seen_in  = seen_ff;
      roles_in = roles_ff;
      phase_in = phase_ff;
      first_in = first_ff;
      mprev_in = mprev_ff;
      mcur_in  = mcur_ff;
      rsp_item = '0;
      wr_en    = 1'b0;
      rotate   = 1'b0;
      advance  = 1'b0;
      clear    = 1'b0;
      if (req_fire) begin
         case (req_func)
            aabc_pkg::FUNC_TEXT: begin
               if (phase_ff != aabc_pkg::DRAIN_NONE || col_ff >= LAST_COL) begin
                  rsp_item.refused      = 1'b1;
                  rsp_item.more_pending = (phase_ff != aabc_pkg::DRAIN_NONE);
               end else begin
                  wr_en = 1'b1;
                  if (col_ff == '0) begin
                     first_in = req_byte;
                  end
                  if (seen_ff != 2'd0 && col_ff < mlen_ff) begin
                     rsp_item.char_bytes = glyph.bytes;
                     rsp_item.byte_count = glyph.count;
                  end
                  col_in = col_plus;
                  if (req_byte == aabc_pkg::CHAR_NL || col_plus >= LAST_COL) begin
                     if (mlen_ff > col_plus) begin
                        phase_in              = aabc_pkg::DRAIN_REST;
                        dcol_in               = col_plus;
                        rsp_item.more_pending = 1'b1;
                        advance               = 1'b1;
                     end else begin
                        rotate = 1'b1;
                     end
                  end else begin
                     advance = 1'b1;
                  end
               end
            end
            aabc_pkg::FUNC_END: begin
               if (phase_ff == aabc_pkg::DRAIN_REST) begin
                  phase_in              = aabc_pkg::DRAIN_REST_END;
                  rsp_item.more_pending = 1'b1;
               end else if (phase_ff == aabc_pkg::DRAIN_NONE) begin
                  if (col_ff != '0) begin
                     if (mlen_ff > col_ff) begin
                        phase_in = aabc_pkg::DRAIN_REST_END;
                        dcol_in  = col_ff;
                     end else begin
                        rotate   = 1'b1;
                        phase_in = aabc_pkg::DRAIN_FINAL;
                        dcol_in  = '0;
                     end
                     rsp_item.more_pending = 1'b1;
                  end else if (mlen_ff != '0) begin
                     phase_in              = aabc_pkg::DRAIN_FINAL;
                     dcol_in               = '0;
                     rsp_item.more_pending = 1'b1;
                  end else begin
                     clear = 1'b1;
                  end
               end
            end
            aabc_pkg::FUNC_DRAIN: begin
               if (phase_ff != aabc_pkg::DRAIN_NONE) begin
                  if (dcol_ff < mlen_ff) begin
                     rsp_item.char_bytes = glyph.bytes;
                     rsp_item.byte_count = glyph.count;
                  end
                  dcol_in = dcol_plus;
                  if (dcol_plus < mlen_ff) begin
                     rsp_item.more_pending = 1'b1;
                     advance               = 1'b1;
                  end else if (phase_ff == aabc_pkg::DRAIN_REST) begin
                     rotate   = 1'b1;
                     phase_in = aabc_pkg::DRAIN_NONE;
                  end else if (phase_ff == aabc_pkg::DRAIN_REST_END) begin
                     rotate                = 1'b1;
                     phase_in              = aabc_pkg::DRAIN_FINAL;
                     dcol_in               = '0;
                     rsp_item.more_pending = 1'b1;
                  end else begin
                     rsp_item.text_done = 1'b1;
                     clear              = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end

      // Shift the window one column
      if (advance) begin
         mprev_in = mcur_ff;
         mcur_in  = mid_rd;
      end

      // Hand the incoming line to the middle role and reload the window
      if (rotate) begin
         alen_in  = mlen_ff;
         mlen_in  = col_in;
         col_in   = '0;
         roles_in = aabc_pkg::role_add(roles_ff, 2'd1);
         if (seen_ff != 2'd2) begin
            seen_in = seen_ff + 2'd1;
         end
         mprev_in = 8'h00;
         mcur_in  = first_in;
      end

      // Drop all line state at the end of a text
      if (clear) begin
         alen_in  = '0;
         mlen_in  = '0;
         col_in   = '0;
         dcol_in  = '0;
         seen_in  = 2'd0;
         phase_in = aabc_pkg::DRAIN_NONE;
      end
   end

   // Prefetch for the column that the next cycle works on
   assign ptr_in   = (phase_in != aabc_pkg::DRAIN_NONE) ? dcol_in : col_in;
   assign wr_addr  = line_addr(aabc_pkg::role_add(roles_ff, 2'd2), col_ff);
   assign mid_addr = line_addr(aabc_pkg::role_add(roles_in, 2'd1), ptr_in + COL_ONE);
   assign abv_addr = line_addr(roles_in, ptr_in);

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         dcol_ff  <= '0;
         alen_ff  <= '0;
         mlen_ff  <= '0;
         seen_ff  <= 2'd0;
         roles_ff <= 2'd0;
         phase_ff <= aabc_pkg::DRAIN_NONE;
      end else begin
         col_ff   <= col_in;
         dcol_ff  <= dcol_in;
         alen_ff  <= alen_in;
         mlen_ff  <= mlen_in;
         seen_ff  <= seen_in;
         roles_ff <= roles_in;
         phase_ff <= phase_in;
      end
   end

   // Hold window bytes
   always_ff @(posedge clock) begin
      mprev_ff <= mprev_in;
      mcur_ff  <= mcur_in;
      first_ff <= first_in;
   end

   // Copy for the right neighbor of the middle line
   aabc_line_mem #(
      .DEPTH (DEPTH),
      .AW    (MAW)
   ) u_mid_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_byte),
      .rd_addr (mid_addr),
      .rd_data (mid_rd)
   );

   // Copy for the line above
   aabc_line_mem #(
      .DEPTH (DEPTH),
      .AW    (MAW)
   ) u_abv_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_byte),
      .rd_addr (abv_addr),
      .rd_data (abv_rd)
   );

   aabc_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_fire),
      .in_item   (rsp_item),
      .in_ready  (buf_ready),
      .out_valid (rsp_tvalid),
      .out_item  (out_item),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata = {4'b0000, out_item.refused, out_item.more_pending,
                       out_item.byte_count, out_item.char_bytes};
   assign rsp_tlast = out_item.text_done;

   `AABC_ASSERT_ALWAYS(a_roles_range, roles_ff != 2'd3, "buffer role index out of range")
   `AABC_ASSERT_IMPLY(a_drain_col_bound, phase_ff != aabc_pkg::DRAIN_NONE, dcol_ff <= mlen_ff, "drain column beyond middle line")
   `AABC_ASSERT_NEXT(a_final_clears, req_fire && req_func == aabc_pkg::FUNC_DRAIN && phase_ff == aabc_pkg::DRAIN_FINAL && dcol_plus >= mlen_ff, mlen_ff == '0 && phase_ff == aabc_pkg::DRAIN_NONE, "line state not cleared after final column")

endmodule

`default_nettype wire

// File: tb/box_char_checker.sv
module box_char_checker #(
   parameter int LINE_LEN = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic [1:0]  req_tuser,   // [1:0] func
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // [23:0] char_bytes, [25:24] byte_count,
                                    // [26] more_pending, [27] refused
   input  logic        rsp_tlast,   // text_done
   output int          error_count,
   output int          open_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import aabc_pkg::*;

   // Neighbor bits of a box character
   localparam int NB_LEFT  = 0;
   localparam int NB_RIGHT = 1;
   localparam int NB_UP    = 2;
   localparam int NB_DOWN  = 3;

   // Low byte of the corner glyph for each neighbor set, entry 15 in the top byte
   localparam logic [127:0] CORNER_LOW = {
      8'hBC, 8'h9C, 8'hA4, 8'h00, 8'hAC, 8'h8C, 8'h90, 8'h00,
      8'hB4, 8'h94, 8'h98, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};

   // Slots 0, 1 and 2 relative to top_slot hold the above, middle and incoming rows
   logic [7:0] line_mem [0:3*LINE_LEN-1];
   int         above_len;
   int         mid_len;
   int         fill_col;
   int         drain_col;
   int         rows_seen;
   int         top_slot;
   drain_type  pending_drain;

   // Results still owed by the converter, oldest first
   rsp_type    awaited_rsp [$];

   function automatic int slot_base(input int slot);
      return ((top_slot + slot) % 3) * LINE_LEN;
   endfunction

   // Work out the glyph for middle-row column col
   function automatic glyph_type middle_glyph(input int col, input bit has_below,
                                              input logic [7:0] below);
      glyph_type  g;
      logic [7:0] c;
      logic [7:0] side;
      logic [7:0] low;
      logic [3:0] touch;
      c       = line_mem[slot_base(1) + col];
      g.bytes = {16'h0000, c};
      g.count = COUNT_ONE;
      touch   = '0;
      if (c == CHAR_PLUS || c == CHAR_DASH || c == CHAR_BAR) begin
         if (col > 0) begin
            side = line_mem[slot_base(1) + col - 1];
            touch[NB_LEFT] = (side == CHAR_DASH) || (side == CHAR_PLUS);
         end
         if (col + 1 < mid_len) begin
            side = line_mem[slot_base(1) + col + 1];
            touch[NB_RIGHT] = (side == CHAR_DASH) || (side == CHAR_PLUS);
         end
         if (col < above_len) begin
            side = line_mem[slot_base(0) + col];
            touch[NB_UP] = (side == CHAR_BAR) || (side == CHAR_PLUS);
         end
         touch[NB_DOWN] = has_below && ((below == CHAR_BAR) || (below == CHAR_PLUS));
         low = CORNER_LOW[int'(touch) * 8 +: 8];
         if (c == CHAR_PLUS) begin
            if (low != 8'h00) begin
               g.bytes = {BOX_LEAD, low};
               g.count = COUNT_BOX;
            end
         end else if (c == CHAR_DASH) begin
            if (touch[NB_LEFT] || touch[NB_RIGHT]) begin
               g.bytes = BOX_HORIZ;
               g.count = COUNT_BOX;
            end
         end else if (touch[NB_UP] || touch[NB_DOWN]) begin
            g.bytes = BOX_VERT;
            g.count = COUNT_BOX;
         end
      end
      return g;
   endfunction

   task automatic clear_text_state();
      above_len     = 0;
      mid_len       = 0;
      fill_col      = 0;
      drain_col     = 0;
      rows_seen     = 0;
      pending_drain = DRAIN_NONE;
   endtask

   // Retire the above row; middle moves up and incoming becomes middle
   task automatic rotate_rows();
      above_len = mid_len;
      mid_len   = fill_col;
      fill_col  = 0;
      top_slot  = (top_slot + 1) % 3;
      if (rows_seen < 2) begin
         rows_seen++;
      end
   endtask

   // Advance the converter by one request and produce its result
   task automatic step_converter(input logic [1:0] fn, input logic [7:0] text,
                                 output rsp_type r);
      glyph_type g;
      int        col;
      r = '0;
      if (fn == FUNC_TEXT) begin
         col = fill_col;
         if (pending_drain != DRAIN_NONE || col >= LINE_LEN - 1) begin
            r.refused      = 1'b1;
            r.more_pending = (pending_drain != DRAIN_NONE);
         end else begin
            line_mem[slot_base(2) + col] = text;
            if (rows_seen >= 1 && col < mid_len) begin
               g            = middle_glyph(col, 1'b1, text);
               r.char_bytes = g.bytes;
               r.byte_count = g.count;
            end
            fill_col = col + 1;
            if (text == CHAR_NL || fill_col >= LINE_LEN - 1) begin
               if (mid_len > fill_col) begin
                  pending_drain  = DRAIN_REST;
                  drain_col      = fill_col;
                  r.more_pending = 1'b1;
               end else begin
                  rotate_rows();
               end
            end
         end
      end else if (fn == FUNC_END) begin
         if (pending_drain == DRAIN_REST) begin
            pending_drain  = DRAIN_REST_END;
            r.more_pending = 1'b1;
         end else if (pending_drain == DRAIN_NONE) begin
            if (fill_col > 0 && mid_len > fill_col) begin
               pending_drain  = DRAIN_REST_END;
               drain_col      = fill_col;
               r.more_pending = 1'b1;
            end else begin
               if (fill_col > 0) begin
                  rotate_rows();
               end
               if (mid_len > 0) begin
                  pending_drain  = DRAIN_FINAL;
                  drain_col      = 0;
                  r.more_pending = 1'b1;
               end else begin
                  clear_text_state();
               end
            end
         end
      end else if (fn == FUNC_DRAIN && pending_drain != DRAIN_NONE) begin
         if (drain_col < mid_len) begin
            g            = middle_glyph(drain_col, 1'b0, 8'h00);
            r.char_bytes = g.bytes;
            r.byte_count = g.count;
         end
         drain_col++;
         if (drain_col < mid_len) begin
            r.more_pending = 1'b1;
         end else if (pending_drain == DRAIN_REST) begin
            rotate_rows();
            pending_drain = DRAIN_NONE;
         end else if (pending_drain == DRAIN_REST_END) begin
            rotate_rows();
            pending_drain  = DRAIN_FINAL;
            drain_col      = 0;
            r.more_pending = 1'b1;
         end else begin
            r.text_done = 1'b1;
            clear_text_state();
         end
      end
   endtask

   function automatic int field_differs(input string name, input logic [23:0] want,
                                        input logic [23:0] got);
      if (want !== got) begin
         $display("%0t rsp %s mismatch: expected %h actual %h", $time, name, want, got);
         return 1;
      end
      return 0;
   endfunction

   // Compare each result transaction, then predict from each request transaction
   always @(posedge clock) begin : watch
      rsp_type want;
      rsp_type got;
      rsp_type made;
      int      bad;
      if (reset) begin
         clear_text_state();
         top_slot = 0;
         awaited_rsp.delete();
         open_count  <= 0;
         error_count <= 0;
      end else begin
         bad = 0;
         if (rsp_tvalid && rsp_tready) begin
            got.char_bytes   = rsp_tdata[23:0];
            got.byte_count   = rsp_tdata[25:24];
            got.more_pending = rsp_tdata[26];
            got.refused      = rsp_tdata[27];
            got.text_done    = rsp_tlast;
            if (awaited_rsp.size() == 0) begin
               $display("%0t unexpected rsp transaction: expected none actual %h last %b",
                        $time, rsp_tdata, rsp_tlast);
               bad++;
            end else begin
               want = awaited_rsp.pop_front();
               bad += field_differs("char_bytes", want.char_bytes, got.char_bytes);
               bad += field_differs("byte_count", want.byte_count, got.byte_count);
               bad += field_differs("more_pending", want.more_pending, got.more_pending);
               bad += field_differs("refused", want.refused, got.refused);
               bad += field_differs("text_done", want.text_done, got.text_done);
            end
         end
         if (req_tvalid && req_tready) begin
            step_converter(req_tuser, req_tdata, made);
            awaited_rsp.push_back(made);
         end
         open_count  <= awaited_rsp.size();
         error_count <= error_count + bad;
      end
   end

endmodule

// File: tb/ascii_art_box_char_converter_tb.sv
module ascii_art_box_char_converter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import aabc_pkg::*;

   localparam int         LINE_LEN   = 256;
   localparam int         ITEM_GOAL  = 1750;
   localparam int         CALM_MARK  = 1500;
   localparam int         END_WAIT   = 100000;
   localparam logic [1:0] FUNC_SPARE = 2'd3;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_VT    = 8'h0B;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] text_byte
   logic [1:0]  req_tuser  = 2'd0;    // [1:0] func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;            // [23:0] char_bytes, [25:24] byte_count,
                                      // [26] more_pending, [27] refused
   logic        rsp_tlast;            // text_done
   int          error_count;
   int          open_count;

   // Sender's view of the row lengths, enough to know how many drains are owed
   int          mid_cols     = 0;
   int          fill_cols    = 0;
   int          rest_owed    = 0;
   int          items_sent   = 0;
   int          tx_idle_pct  = 0;
   int          rx_stall_pct = 0;
   int          noise_pct    = 0;
   int          stall_left   = 0;
   int          prev_len     = 0;
   logic [7:0]  prev_row [0:LINE_LEN-1];

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   ascii_art_box_char_converter #(
      .LINE_LEN (LINE_LEN)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   box_char_checker #(
      .LINE_LEN (LINE_LEN)
   ) checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .error_count (error_count),
      .open_count  (open_count)
   );

   // Stall the result channel in bursts of random length
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if ($urandom_range(99) < rx_stall_pct) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(13, 0);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Hold one request transaction until it is taken, after an optional idle burst
   task automatic send_item(input logic [1:0] fn, input logic [7:0] data);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(14, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= fn;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic shift_rows();
      mid_cols  = fill_cols;
      fill_cols = 0;
   endtask

   // Send one text byte and note where its row ends
   task automatic put_text(input logic [7:0] data);
      send_item(FUNC_TEXT, data);
      items_sent++;
      fill_cols++;
      if (data == CHAR_NL || fill_cols == LINE_LEN - 1) begin
         if (mid_cols > fill_cols) begin
            rest_owed = mid_cols - fill_cols;
         end else begin
            shift_rows();
         end
      end
   endtask

   // Send one drain step, sometimes behind a text byte that must be refused
   task automatic drain_one();
      if ($urandom_range(99) < noise_pct) begin
         send_item(FUNC_TEXT, 8'($urandom_range(255)));
      end
      send_item(FUNC_DRAIN, 8'($urandom_range(255)));
      items_sent++;
   endtask

   task automatic pay_rest();
      while (rest_owed > 0) begin
         drain_one();
         rest_owed--;
      end
      shift_rows();
   endtask

   // Close the text and drain what is left, including the last row
   task automatic end_text();
      int k;
      send_item(FUNC_END, 8'($urandom_range(255)));
      items_sent++;
      if (rest_owed > 0) begin
         pay_rest();
      end else if (fill_cols > 0) begin
         if (mid_cols > fill_cols) begin
            rest_owed = mid_cols - fill_cols;
            pay_rest();
         end else begin
            shift_rows();
         end
      end
      for (k = 0; k < mid_cols; k++) begin
         // a repeated end while the last row drains is ignored
         if ($urandom_range(99) < noise_pct) begin
            send_item(FUNC_END, 8'($urandom_range(255)));
         end
         drain_one();
      end
      mid_cols  = 0;
      fill_cols = 0;
   endtask

   // Pause the sender until every result has come back
   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (open_count != 0);
   endtask

   // Mostly box pieces; newline is kept out since it would end the row early
   function automatic logic [7:0] art_byte();
      int         pick;
      logic [7:0] b;
      pick = $urandom_range(99);
      if (pick < 30) begin
         b = CHAR_PLUS;
      end else if (pick < 55) begin
         b = CHAR_DASH;
      end else if (pick < 78) begin
         b = CHAR_BAR;
      end else if (pick < 88) begin
         b = CHAR_SPACE;
      end else begin
         b = 8'($urandom_range(255));
      end
      if (b == CHAR_NL) begin
         b = CHAR_VT;
      end
      return b;
   endfunction

   initial begin : stimulus
      int         text_no;
      int         lines;
      int         row;
      int         n;
      int         j;
      int         waited;
      bit         last;
      bit         partial;
      logic [7:0] b;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: stray drain, spare code and empty text first
      send_item(FUNC_DRAIN, 8'hFF);
      send_item(FUNC_SPARE, 8'h00);
      send_item(FUNC_END, 8'hFF);

      // Small box whose last row is short; end arrives while its remainder is owed
      put_text(CHAR_PLUS);
      put_text(CHAR_DASH);
      put_text(CHAR_PLUS);
      put_text(CHAR_NL);
      put_text(CHAR_BAR);
      put_text(8'h00);
      put_text(CHAR_BAR);
      put_text(CHAR_NL);
      put_text(CHAR_PLUS);
      put_text(CHAR_NL);
      noise_pct = 100;
      end_text();
      noise_pct = 0;

      // Single-row text
      put_text(CHAR_DASH);
      put_text(CHAR_BAR);
      put_text(CHAR_NL);
      end_text();
      wait_quiet();

      // Random texts of loosely aligned box rows
      text_no = 0;
      while (items_sent < ITEM_GOAL) begin
         if (items_sent >= CALM_MARK) begin
            tx_idle_pct   = 0;
            rx_stall_pct <= 0;
         end else begin
            case ($urandom_range(2))
               0: tx_idle_pct = 0;
               1: tx_idle_pct = 8;
               default: tx_idle_pct = 30;
            endcase
            case ($urandom_range(2))
               0: rx_stall_pct <= 0;
               1: rx_stall_pct <= 10;
               default: rx_stall_pct <= 35;
            endcase
         end
         noise_pct = $urandom_range(1) ? 0 : 10;
         lines     = (text_no == 0) ? 4 : $urandom_range(6, 1);
         prev_len  = 0;
         for (row = 0; row < lines; row++) begin
            last = (row == lines - 1);
            if (text_no == 0 && row < 2) begin
               // a row that ends at the length limit with no newline, then a row that just fits with its newline
               n = (row == 0) ? LINE_LEN - 1 : LINE_LEN - 2;
            end else if ($urandom_range(99) < 3) begin
               n = $urandom_range(LINE_LEN - 1, 100);
            end else begin
               n = $urandom_range(18, 0);
            end
            partial = last && n > 0 && n < LINE_LEN - 1 && $urandom_range(1);
            for (j = 0; j < n; j++) begin
               if (j < prev_len && $urandom_range(1)) begin
                  b = prev_row[j];
               end else begin
                  b = art_byte();
               end
               prev_row[j] = b;
               put_text(b);
            end
            prev_len = n;
            if (n < LINE_LEN - 1 && !partial) begin
               put_text(CHAR_NL);
            end
            // on the last row the end may overtake the owed remainder
            if (rest_owed > 0 && !(last && $urandom_range(1))) begin
               pay_rest();
            end
            if (rest_owed == 0 && $urandom_range(9) == 0) begin
               send_item($urandom_range(1) ? FUNC_DRAIN : FUNC_SPARE,
                         8'($urandom_range(255)));
            end
         end
         end_text();
         if ($urandom_range(7) == 0) begin
            wait_quiet();
         end
         text_no++;
      end

      // Drain the result channel and give the verdict
      req_tvalid <= 1'b0;
      waited = 0;
      do begin
         @(posedge clock);
         waited++;
      end while (open_count != 0 && waited < END_WAIT);
      repeat (10) @(posedge clock);
      if (open_count != 0 || error_count != 0) begin
         $display("FAIL ascii_art_box_char_converter");
      end else begin
         $display("PASS ascii_art_box_char_converter");
      end
      $finish;
   end

   // Stop a hung run
   initial begin : watchdog
      #20_000_000;
      $display("FAIL ascii_art_box_char_converter");
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/aabc_pkg.sv
rtl/aabc_line_mem.sv
rtl/aabc_rsp_buf.sv
rtl/ascii_art_box_char_converter.sv
tb/box_char_checker.sv
tb/ascii_art_box_char_converter_tb.sv
